/* rtl/core/matrix_vector_multiply_defines.svh */
// Assertion macros shared by the matrix-vector multiply RTL.
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MVM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mvm check failed");

// Next-cycle implication, also checked while reset is applied.
`define MVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mvm check failed");

`endif

/* rtl/core/mvm_pkg.sv */
// Types and constants for the matrix-vector multiply block.
package mvm_pkg;

  localparam int ELEM_W  = 16;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 10;
  localparam int ACC_W   = 40;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ROWS_W  = 11;
  localparam int COLS_W  = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_IN_USE = 1'b1;

  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_MATRIX = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic                     action;
    logic [COL_W-1:0]         column;
    logic signed [ELEM_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [ACC_W-1:0] dot_product;
    logic                    last_row;
  } out_item_t;

  // Stage-1 control handed to the MAC.
  typedef struct packed {
    logic valid;
    logic in_range;
    logic row_end;
  } mac_ctrl_t;

endpackage

/* rtl/core/matrix_vector_multiply.sv */
// Matrix-vector multiply in signed Q4.12, top level.
//
// Input channel (in_valid/in_stall/in_item): action 0 writes element_value into
// the vector store at column; action 1 streams a matrix element, row-major, which
// is multiplied by the stored vector element of its column and accumulated.
// The matrix element at the last column in use closes the row and produces one
// result item on out_valid/out_stall/out_item: row number, 40-bit Q16.24 dot
// product (saturating) and a last-row flag. Other items produce no result.
// One item is taken per cycle while in_stall is low. A row result reaches
// out_valid from its closing item through three registers: vector RAM read (at
// the accepting edge), multiply register, accumulate into the output register.
// The vector lives in a registered-read RAM; a load is visible to any matrix
// item accepted after it.
// When the receiver stalls, one more result is held in a skid entry; once it is
// full, in_stall rises until the output register drains.
// Reset (rst, synchronous) clears the accumulator, row counter and output side
// and sets both sizes to 1; the vector store is not cleared and must be loaded.
// Write sizes on cfg_* (always ready) only while the block is idle (unchecked).
`include "matrix_vector_multiply_defines.svh"
module matrix_vector_multiply
  import mvm_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [ROWS_W-1:0] rows_in_use;
  logic [COLS_W-1:0] columns_in_use;
  logic [ROWS_W-1:0] rows_last;
  logic [COLS_W-1:0] cols_last;
  logic              en;
  logic              accept;
  logic              col_ok;
  logic              skid_full;
  logic [ELEM_W-1:0] vec_raw;
  mac_ctrl_t         ctl1;
  logic signed [ELEM_W-1:0] val1;
  logic              res_valid;
  out_item_t         res_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use    <= ROWS_W'(1);
      columns_in_use <= COLS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS_IN_USE:    rows_in_use    <= cfg_data[ROWS_W-1:0];
        CFG_COLUMNS_IN_USE: columns_in_use <= cfg_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above the maximum acts as the maximum.
  always_comb begin
    if (rows_in_use == '0) begin
      rows_last = '0;
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      rows_last = ROWS_W'(MAX_ROWS - 1);
    end else begin
      rows_last = rows_in_use - 1'b1;
    end
    if (columns_in_use == '0) begin
      cols_last = '0;
    end else if (int'(columns_in_use) > MAX_COLUMNS) begin
      cols_last = COLS_W'(MAX_COLUMNS - 1);
    end else begin
      cols_last = columns_in_use - 1'b1;
    end
  end

  assign en       = !skid_full;
  assign in_stall = skid_full;
  assign accept   = in_valid && !in_stall;
  assign col_ok   = int'(in_item.column) < MAX_COLUMNS;

  mvm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_COLUMNS)
  ) u_vec_ram (
    .clk     (clk),
    .wr_en   (accept && in_item.action == ACTION_LOAD && col_ok),
    .wr_addr (AW'(in_item.column)),
    .wr_data (in_item.element_value),
    .rd_en   (en),
    .rd_addr (AW'(in_item.column)),
    .rd_data (vec_raw)
  );

  // Stage 1, aligned with the RAM read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else if (en) begin
      ctl1.valid <= accept && in_item.action == ACTION_MATRIX;
    end
    if (en) begin
      ctl1.in_range <= col_ok;
      ctl1.row_end  <= COLS_W'(in_item.column) == cols_last;
      val1          <= in_item.element_value;
    end
  end

  mvm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl       (ctl1),
    .mat_value (val1),
    .vec_value ($signed(vec_raw)),
    .rows_last (rows_last),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  mvm_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_item  (res_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .full      (skid_full)
  );

  `MVM_ASSERT_IMPL(a_skid_behind_out, skid_full, out_valid)
  `MVM_ASSERT_IMPL(a_no_result_into_full, res_valid, !skid_full)
  `MVM_ASSERT_NEXT(a_reset_empties_out, rst, !out_valid && !skid_full)

endmodule

/* rtl/core/mvm_ram.sv */
// Generic single-port-write, registered-read RAM.
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]               wr_data,
  input  logic                           rd_en,
  input  logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]               rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/mvm_mac.sv */
// Multiply stage, saturating accumulator and row counter.
module mvm_mac
  import mvm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  mac_ctrl_t                ctl,
  input  logic signed [ELEM_W-1:0] mat_value,
  input  logic signed [ELEM_W-1:0] vec_value,
  input  logic [ROWS_W-1:0]        rows_last,
  output logic                     res_valid,
  output out_item_t                res_item
);

  logic                     v2;
  logic                     end2;
  logic signed [PROD_W-1:0] prod2;
  logic signed [ELEM_W-1:0] vec_eff;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  acc_sat;
  logic [ROW_W-1:0]         row_cnt;
  logic                     is_last;

  // Columns beyond the store multiply by zero.
  assign vec_eff = ctl.in_range ? vec_value : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      end2  <= ctl.row_end;
      prod2 <= PROD_W'(mat_value) * PROD_W'(vec_eff);
    end
  end

  always_comb begin
    sum = (ACC_W+1)'(acc) + (ACC_W+1)'(prod2);
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = sum[ACC_W-1:0];
    end
  end

  assign is_last   = ROWS_W'(row_cnt) >= rows_last;
  assign res_valid = en && v2 && end2;

  always_comb begin
    res_item.row_index   = row_cnt;
    res_item.dot_product = acc_sat;
    res_item.last_row    = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      row_cnt <= '0;
    end else if (en && v2) begin
      acc <= end2 ? '0 : acc_sat;
      if (end2) begin
        row_cnt <= is_last ? '0 : row_cnt + 1'b1;
      end
    end
  end

endmodule

/* rtl/core/mvm_skid.sv */
// Output register with one skid entry behind it.
module mvm_skid
  import mvm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      res_valid,
  input  out_item_t res_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  output logic      full
);

  out_item_t skid_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      full      <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (full) begin
        out_valid <= 1'b1;
        full      <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (full) begin
        out_item <= skid_item;
      end else if (res_valid) begin
        out_item <= res_item;
      end
    end else if (res_valid) begin
      skid_item <= res_item;
    end
  end

endmodule
